@@ sv/tne_pkg.sv @@
// Shared types, constants and helpers of the torus neighbor enumerator.
package tne_pkg;

   localparam int MAX_DIMS        = 3;
   localparam int ID_BITS_DEFAULT = 16;
   localparam int SIZE_W          = 16;
   localparam int ID_W            = 16;
   localparam int STEP_W          = 2;
   localparam int NUM_ORDS        = 3;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_COUNT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_DIM0    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_DIM1    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_DIM2    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE = 3'd4;

   // Step codes as they appear on the result channel.
   localparam logic [STEP_W-1:0] STEP_NONE  = 2'd0;
   localparam logic [STEP_W-1:0] STEP_MINUS = 2'd1;
   localparam logic [STEP_W-1:0] STEP_PLUS  = 2'd2;

   // Scan ordinals: the order in which steps of one dimension are visited.
   localparam logic [1:0] ORD_MINUS = 2'd0;
   localparam logic [1:0] ORD_NONE  = 2'd1;
   localparam logic [1:0] ORD_PLUS  = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       div_step;
      logic       div_last;
      logic       mult_setup;
      logic       term_en;
      logic       scan_init;
      logic       scan_next;
      logic       emit;
      logic [1:0] dim;
      logic [1:0] ord;
   } cmd_type;

   typedef struct packed {
      logic [1:0] used_dims;
      logic       take;
      logic       last;
      logic       out_free;
   } status_type;

   function automatic logic [STEP_W-1:0] ord_to_step(input logic [1:0] ord);
      logic [STEP_W-1:0] step;
      case (ord)
         ORD_MINUS: step = STEP_MINUS;
         ORD_PLUS:  step = STEP_PLUS;
         default:   step = STEP_NONE;
      endcase
      return step;
   endfunction

endpackage

@@ sv/tne_ctrl.sv @@
// Sequencer of the torus neighbor enumerator: divide, scale and scan phases.
module tne_ctrl #(
   parameter int ID_BITS = tne_pkg::ID_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tne_pkg::status_type  status,
   output tne_pkg::cmd_type     cmd
);
   import tne_pkg::*;

   localparam int CNT_W = (ID_BITS > 1) ? $clog2(ID_BITS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SETUP,
      ST_TERM,
      ST_SCAN
   } state_type;

   state_type        state_ff;
   logic [1:0]       dim_ff;
   logic [1:0]       ord_ff;
   logic [CNT_W-1:0] bit_ff;
   logic             bit_last;
   logic             dim_last;

   assign bit_last  = (bit_ff == CNT_W'(ID_BITS - 1));
   assign dim_last  = (dim_ff == status.used_dims - 2'd1);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd     = '0;
      cmd.dim = dim_ff;
      cmd.ord = ord_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cmd.div_last = bit_last;
         end
         ST_SETUP: begin
            cmd.mult_setup = 1'b1;
            cmd.scan_init  = 1'b1;
         end
         ST_TERM: begin
            cmd.term_en = 1'b1;
         end
         ST_SCAN: begin
            // Candidates that are filtered out are skipped at one per cycle.
            if (status.take) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.scan_next = !status.last;
               end
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dim_ff   <= '0;
         ord_ff   <= ORD_MINUS;
         bit_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_DIVIDE;
                  dim_ff   <= '0;
                  bit_ff   <= '0;
               end
            end
            ST_DIVIDE: begin
               bit_ff <= bit_ff + CNT_W'(1);
               if (bit_last) begin
                  bit_ff <= '0;
                  if (dim_last) begin
                     state_ff <= ST_SETUP;
                  end else begin
                     dim_ff <= dim_ff + 2'd1;
                  end
               end
            end
            ST_SETUP: begin
               state_ff <= ST_TERM;
               dim_ff   <= '0;
               ord_ff   <= ORD_MINUS;
            end
            ST_TERM: begin
               if (ord_ff == ORD_PLUS) begin
                  ord_ff <= ORD_MINUS;
                  if (dim_last) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     dim_ff <= dim_ff + 2'd1;
                  end
               end else begin
                  ord_ff <= ord_ff + 2'd1;
               end
            end
            ST_SCAN: begin
               if (status.take && status.out_free && status.last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ sv/tne_datapath.sv @@
// Datapath of the torus neighbor enumerator: registers, divider, multiplier and scan.
module tne_datapath #(
   parameter int ID_BITS = tne_pkg::ID_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [tne_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tne_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [tne_pkg::ID_W-1:0]              req_own_id,
   input  tne_pkg::cmd_type                      cmd,
   output tne_pkg::status_type                   status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [tne_pkg::ID_W-1:0]              rsp_neighbor_id,
   output logic [tne_pkg::STEP_W-1:0]            rsp_step_dim0,
   output logic [tne_pkg::STEP_W-1:0]            rsp_step_dim1,
   output logic [tne_pkg::STEP_W-1:0]            rsp_step_dim2,
   output logic                                  rsp_last
);
   import tne_pkg::*;

   localparam int PROD_W = SIZE_W + ID_BITS;

   // Configuration registers.
   logic [1:0]        dim_count_ff;
   logic [SIZE_W-1:0] size_ff [MAX_DIMS];
   logic [1:0]        max_dist_ff;

   // Working registers.
   logic [SIZE_W-1:0]  div_rem_ff;
   logic [ID_BITS-1:0] div_work_ff;
   logic [SIZE_W-1:0]  coord_ff [MAX_DIMS];
   logic [ID_BITS-1:0] mult_ff  [MAX_DIMS];
   logic [ID_BITS-1:0] term_ff  [MAX_DIMS][NUM_ORDS];
   logic [1:0]         digit_ff [MAX_DIMS];

   // Output register.
   logic               rsp_valid_ff;
   logic [ID_W-1:0]    rsp_neighbor_id_ff;
   logic [STEP_W-1:0]  rsp_step_dim0_ff;
   logic [STEP_W-1:0]  rsp_step_dim1_ff;
   logic [STEP_W-1:0]  rsp_step_dim2_ff;
   logic               rsp_last_ff;

   logic [SIZE_W-1:0]  eff_size [MAX_DIMS];
   logic [1:0]         used_dims;
   logic [SIZE_W:0]    div_shift;
   logic               div_fits;
   logic [SIZE_W-1:0]  div_rem_in;
   logic [ID_BITS-1:0] div_work_in;
   logic [SIZE_W-1:0]  sel_coord;
   logic [SIZE_W-1:0]  sel_size;
   logic [SIZE_W-1:0]  wrap_coord;
   logic [SIZE_W-1:0]  mul_a;
   logic [ID_BITS-1:0] mul_b;
   logic [PROD_W-1:0]  product;
   logic [ID_BITS-1:0] cand_sum;
   logic [1:0]         cand_steps;
   logic [1:0]         last_reach;
   logic               cand_take;
   logic               cand_last;
   logic [1:0]         digit_in [MAX_DIMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= 2'd1;
         max_dist_ff  <= 2'd1;
         for (int d = 0; d < MAX_DIMS; d++) begin
            size_ff[d] <= SIZE_W'(1);
         end
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DIM_COUNT:    dim_count_ff <= csr_wdata[1:0];
            CSR_SIZE_DIM0:    size_ff[0]   <= csr_wdata[SIZE_W-1:0];
            CSR_SIZE_DIM1:    size_ff[1]   <= csr_wdata[SIZE_W-1:0];
            CSR_SIZE_DIM2:    size_ff[2]   <= csr_wdata[SIZE_W-1:0];
            CSR_MAX_DISTANCE: max_dist_ff  <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // A zero size behaves as size one; a zero dimension count as one.
   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         eff_size[d] = (size_ff[d] == '0) ? SIZE_W'(1) : size_ff[d];
      end
      if (dim_count_ff == 2'd0) begin
         used_dims = 2'd1;
      end else if (dim_count_ff > 2'(MAX_DIMS)) begin
         used_dims = 2'(MAX_DIMS);
      end else begin
         used_dims = dim_count_ff;
      end
   end

   // Restoring divider, one quotient bit per cycle. The dividend shifts out of
   // the top of the work register while quotient bits enter at the bottom.
   always_comb begin
      div_shift   = {div_rem_ff, div_work_ff[ID_BITS-1]};
      div_fits    = (div_shift >= {1'b0, eff_size[cmd.dim]});
      div_rem_in  = div_fits ? SIZE_W'(div_shift - {1'b0, eff_size[cmd.dim]})
                             : div_shift[SIZE_W-1:0];
      div_work_in = {div_work_ff[ID_BITS-2:0], div_fits};
   end

   // Shared multiplier: place weight of dimension two, then one scaled
   // coordinate per cycle for each dimension and step.
   always_comb begin
      sel_coord = coord_ff[cmd.dim];
      sel_size  = eff_size[cmd.dim];
      case (cmd.ord)
         ORD_MINUS: wrap_coord = (sel_coord == '0) ? sel_size - SIZE_W'(1)
                                                   : sel_coord - SIZE_W'(1);
         ORD_PLUS:  wrap_coord = (sel_coord >= sel_size - SIZE_W'(1)) ? '0
                                                   : sel_coord + SIZE_W'(1);
         default:   wrap_coord = sel_coord;
      endcase
      mul_a   = cmd.mult_setup ? eff_size[1] : wrap_coord;
      mul_b   = cmd.mult_setup ? mult_ff[1]  : mult_ff[cmd.dim];
      product = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         div_work_ff <= ID_BITS'(req_own_id);
         div_rem_ff  <= '0;
         mult_ff[0]  <= ID_BITS'(1);
         mult_ff[1]  <= ID_BITS'(eff_size[0]);
         for (int d = 0; d < MAX_DIMS; d++) begin
            coord_ff[d] <= '0;
            for (int o = 0; o < NUM_ORDS; o++) begin
               term_ff[d][o] <= '0;
            end
         end
      end
      if (cmd.div_step) begin
         div_work_ff <= div_work_in;
         div_rem_ff  <= cmd.div_last ? '0 : div_rem_in;
         if (cmd.div_last) begin
            coord_ff[cmd.dim] <= div_rem_in;
         end
      end
      if (cmd.mult_setup) begin
         mult_ff[2] <= product[ID_BITS-1:0];
      end
      if (cmd.term_en) begin
         term_ff[cmd.dim][cmd.ord] <= product[ID_BITS-1:0];
      end
      if (cmd.scan_init) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            digit_ff[d] <= (2'(d) < used_dims) ? ORD_MINUS : ORD_NONE;
         end
      end else if (cmd.scan_next) begin
         digit_ff <= digit_in;
      end
   end

   // Candidate step vector: its encoded id, whether it is emitted and whether
   // it is the final one. The final neighbor steps plus in the leading
   // dimensions up to the distance limit and nowhere else.
   always_comb begin
      cand_sum   = term_ff[0][digit_ff[0]] + term_ff[1][digit_ff[1]]
                 + term_ff[2][digit_ff[2]];
      cand_steps = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         cand_steps = cand_steps + 2'(digit_ff[d] != ORD_NONE);
      end
      last_reach = (max_dist_ff < used_dims) ? max_dist_ff : used_dims;
      if (max_dist_ff == 2'd0) begin
         cand_take = (cand_steps == 2'd0);
         cand_last = 1'b1;
      end else begin
         cand_take = (cand_steps != 2'd0) && (cand_steps <= max_dist_ff);
         cand_last = 1'b1;
         for (int d = 0; d < MAX_DIMS; d++) begin
            if (digit_ff[d] != ((2'(d) < last_reach) ? ORD_PLUS : ORD_NONE)) begin
               cand_last = 1'b0;
            end
         end
      end
   end

   // Ternary increment; the highest dimension in use is the fastest digit.
   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int d = MAX_DIMS - 1; d >= 0; d--) begin
         digit_in[d] = digit_ff[d];
         if ((2'(d) < used_dims) && carry) begin
            if (digit_ff[d] == ORD_PLUS) begin
               digit_in[d] = ORD_MINUS;
            end else begin
               digit_in[d] = digit_ff[d] + 2'd1;
               carry       = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_neighbor_id_ff <= ID_W'(cand_sum);
         rsp_step_dim0_ff   <= ord_to_step(digit_ff[0]);
         rsp_step_dim1_ff   <= ord_to_step(digit_ff[1]);
         rsp_step_dim2_ff   <= ord_to_step(digit_ff[2]);
         rsp_last_ff        <= cand_last;
      end
   end

   assign status.used_dims = used_dims;
   assign status.take      = cand_take;
   assign status.last      = cand_last;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_neighbor_id = rsp_neighbor_id_ff;
   assign rsp_step_dim0   = rsp_step_dim0_ff;
   assign rsp_step_dim1   = rsp_step_dim1_ff;
   assign rsp_step_dim2   = rsp_step_dim2_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ sv/torus_neighbor_enumerator_unit.sv @@
// Torus neighbor enumerator: one node id in, every neighbor within the
// configured step distance out, one per result, the final one marked by last.
// A request is decoded into coordinates by a restoring divider, dimension
// by dimension in use, then a single shared multiplier forms the weight of
// the top dimension and then the scaled wrapped coordinates of each
// dimension and step. The scan then visits one candidate step vector per
// cycle, up to 3 to the power of the dimension count, and emits a result on
// each candidate that qualifies, waiting while the output register is full.
// The next request is taken as soon as the final result is in the output
// register.
// Configuration must only be written while no request is in progress.
module torus_neighbor_enumerator_unit #(
   parameter int ID_BITS = tne_pkg::ID_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [tne_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tne_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tne_pkg::ID_W-1:0]       req_own_id,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tne_pkg::ID_W-1:0]       rsp_neighbor_id,
   output logic [tne_pkg::STEP_W-1:0]     rsp_step_dim0,
   output logic [tne_pkg::STEP_W-1:0]     rsp_step_dim1,
   output logic [tne_pkg::STEP_W-1:0]     rsp_step_dim2,
   output logic                           rsp_last
);
   import tne_pkg::*;

   cmd_type    cmd;
   status_type status;

   tne_ctrl #(
      .ID_BITS (ID_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tne_datapath #(
      .ID_BITS (ID_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_own_id      (req_own_id),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_neighbor_id (rsp_neighbor_id),
      .rsp_step_dim0   (rsp_step_dim0),
      .rsp_step_dim1   (rsp_step_dim1),
      .rsp_step_dim2   (rsp_step_dim2),
      .rsp_last        (rsp_last)
   );

endmodule

@@ sv/tne_checker.sv @@
// Port-level checks of the torus neighbor enumerator and their binding.
module tne_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           csr_write_en,
   input logic [tne_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [tne_pkg::CSR_DATA_W-1:0] csr_wdata,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [tne_pkg::ID_W-1:0]       req_own_id,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [tne_pkg::ID_W-1:0]       rsp_neighbor_id,
   input logic [tne_pkg::STEP_W-1:0]     rsp_step_dim0,
   input logic [tne_pkg::STEP_W-1:0]     rsp_step_dim1,
   input logic [tne_pkg::STEP_W-1:0]     rsp_step_dim2,
   input logic                           rsp_last
);
   import tne_pkg::*;

   // A held result stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_neighbor_id) && $stable(rsp_last)
         && $stable(rsp_step_dim0) && $stable(rsp_step_dim1)
         && $stable(rsp_step_dim2))
      else $error("stalled result changed");

   // A new request is never taken right after one was accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the previous one is in progress");

   // Until the final result of a request is out, no new request is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken before the final result was produced");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_step_dim0 != 2'd3 && rsp_step_dim1 != 2'd3
         && rsp_step_dim2 != 2'd3)
      else $error("result carries an undefined step code");

endmodule

bind torus_neighbor_enumerator_unit tne_checker u_checker (.*);
